>>> hw/rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// word layouts, operation codes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none
package dtt_pkg;
	localparam int NUM_TIMERS = 16;
	localparam int SLOT_BITS  = 4;
	localparam int TIME_BITS  = 48;
	localparam int PER_BITS   = 32;
	localparam logic [PER_BITS-1:0] ROLLBACK_RESET = PER_BITS'(60 * 60 * 1000);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_CANCEL  = 3'd1,
		OP_REFRESH = 3'd2,
		OP_RESET   = 3'd3,
		OP_COLLECT = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic [SLOT_BITS-1:0] slot;
		logic [PER_BITS-1:0]  period_ms;
		logic                 repeat_req;
		logic                 rearm_now;
		logic [TIME_BITS-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic                 ok;
		logic [SLOT_BITS-1:0] result_slot;
		logic                 slot_present;
		logic [TIME_BITS-1:0] remaining_ms;
		logic                 front_notice;
		logic                 last_result;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_FRONT,
		ST_SCAN,
		ST_FIRE,
		ST_DONE
	} state_t;

	// saturating add of a period onto a time
	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] a, input logic [PER_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS+1-PER_BITS){1'b0}}, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/deadline_timer_table.sv
// ----------------------------------------------------------------------------
// deadline_timer_table: sixteen timer slots ordered by deadline
// add, cancel, refresh, reset, collect expired and query next
// ----------------------------------------------------------------------------
// usage
// - a command word is taken when start is high and busy is low; busy stays
//   high until the last result word of that command has been strobed out
// - result words appear on result for one cycle each with done high; the
//   receiver cannot stall, the final word of a command has last_result set
// - the user must write the rollback window register via cfg_valid / cfg_ready
//   only while the block is idle (not enforced here); cfg_ready is always high
// - deadlines and periods live in two small rams read one slot per cycle,
//   so every pass over the table reads all sixteen slots in turn
// - add and reset: the update state, the front scan, then the result word
// - cancel, refresh, and a reset on an idle slot: the update state, then
//   the result word; query: a scan, then the result word; unused kinds:
//   the result word alone
// - collect: a scan and one result word with nothing due, else a scan and
//   a fire word per fired slot, so sixteen of each with all sixteen due
// - the block returns to idle after every command before taking the next
// - reset clears valid, repeat marks, the pending notice and the last
//   collect time; ram contents are only used for armed slots
// ----------------------------------------------------------------------------
`default_nettype none
module deadline_timer_table (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire dtt_pkg::in_word_t cmd,
	output logic                   done,
	output dtt_pkg::out_word_t     result,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [31:0]             cfg_data
);
	localparam int SB = dtt_pkg::SLOT_BITS;
	localparam int TB = dtt_pkg::TIME_BITS;
	localparam int PB = dtt_pkg::PER_BITS;
	localparam int NT = dtt_pkg::NUM_TIMERS;

	dtt_pkg::state_t state_q, state_d;
	dtt_pkg::in_word_t cmd_q;
	logic [NT-1:0] valid_q, rep_q, due_q;
	logic          notice_q;
	logic [TB-1:0] last_coll_q;
	logic [PB-1:0] window_q;

	// scan bookkeeping
	logic [SB:0]   idx_q;      // read address pipeline: issue index
	logic [SB-1:0] rd_idx_q;   // slot whose data is in ram output now
	logic          rd_vld_q;
	logic          found_q;
	logic [SB-1:0] pick_q;
	logic [TB-1:0] best_q;
	logic          front_q;
	logic          rollback_q;
	logic          upd_ok_q;

	// ram ports
	logic          dl_we, pr_we;
	logic [SB-1:0] wr_addr, rd_addr;
	logic [TB-1:0] dl_wdata, dl_rdata;
	logic [PB-1:0] pr_wdata, pr_rdata;

	dtt_ram #(.WIDTH(TB), .DEPTH(NT)) u_dl_ram (
		.clk(clk), .we(dl_we), .waddr(wr_addr), .wdata(dl_wdata),
		.raddr(rd_addr), .rdata(dl_rdata)
	);
	dtt_ram #(.WIDTH(PB), .DEPTH(NT)) u_pr_ram (
		.clk(clk), .we(pr_we), .waddr(wr_addr), .wdata(pr_wdata),
		.raddr(rd_addr), .rdata(pr_rdata)
	);

	assign cfg_ready = 1'b1;
	assign busy = (state_q != dtt_pkg::ST_IDLE);

	logic accept;
	assign accept = start && !busy;

	// shared compare of the ram deadline against the key, which is always best_q
	logic [TB-1:0] key;
	logic          cmp_lt, cmp_le;
	assign cmp_lt = dl_rdata < key;
	assign cmp_le = dl_rdata <= key;

	// shifted deadline for reset without rearm
	logic [PB-1:0] pdiff;
	logic [TB-1:0] shifted;
	always_comb begin
		pdiff = cmd_q.period_ms - pr_rdata;
		if (cmd_q.period_ms >= pr_rdata) begin
			shifted = dtt_pkg::sat_add(dl_rdata, pdiff);
		end else begin
			pdiff = pr_rdata - cmd_q.period_ms;
			shifted = (dl_rdata > TB'(pdiff)) ? dl_rdata - TB'(pdiff) : '0;
		end
	end

	logic bad_slot;
	assign bad_slot = (cmd_q.kind != dtt_pkg::OP_ADD) && !valid_q[cmd_q.slot];

	logic scan_end;
	assign scan_end = rd_vld_q && (rd_idx_q == SB'(NT - 1));

	logic scan_step;
	assign scan_step = (state_q == dtt_pkg::ST_SCAN || state_q == dtt_pkg::ST_FRONT) &&
		!scan_end && idx_q < (SB+1)'(NT);

	// collect: slot now on the ram output is due and earlier than the best so far
	logic scan_hit;
	assign scan_hit = rd_vld_q && due_q[rd_idx_q] && valid_q[rd_idx_q] &&
		(rollback_q || dl_rdata <= cmd_q.now_ms) && (!found_q || cmp_lt);

	// front test: another armed slot at or below the new deadline
	logic front_hit;
	assign front_hit = rd_vld_q && (rd_idx_q != cmd_q.slot) && valid_q[rd_idx_q] && cmp_le;

	// due slots left once the picked one fires; none left marks the final word
	logic [NT-1:0] due_rest;
	assign due_rest = due_q & ~(NT'(1) << pick_q);

	always_comb begin
		state_d  = state_q;
		dl_we    = 1'b0;
		pr_we    = 1'b0;
		wr_addr  = cmd_q.slot;
		dl_wdata = dtt_pkg::sat_add(cmd_q.now_ms, cmd_q.period_ms);
		pr_wdata = cmd_q.period_ms;
		rd_addr  = idx_q[SB-1:0];
		key      = best_q;
		done     = 1'b0;
		result   = '0;
		unique case (state_q)
			dtt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						dtt_pkg::OP_ADD, dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH,
						dtt_pkg::OP_RESET: state_d = dtt_pkg::ST_UPDATE;
						dtt_pkg::OP_COLLECT, dtt_pkg::OP_QUERY: state_d = dtt_pkg::ST_SCAN;
						default: state_d = dtt_pkg::ST_DONE;
					endcase
				end
				rd_addr = cmd.slot;
			end
			dtt_pkg::ST_UPDATE: begin
				// ram holds the addressed slot
				if (bad_slot) begin
					state_d = dtt_pkg::ST_DONE;
				end else begin
					case (cmd_q.kind)
						dtt_pkg::OP_ADD: begin
							dl_we = 1'b1;
							pr_we = 1'b1;
							state_d = dtt_pkg::ST_FRONT;
						end
						dtt_pkg::OP_REFRESH: begin
							dl_we = 1'b1;
							dl_wdata = dtt_pkg::sat_add(cmd_q.now_ms, pr_rdata);
							state_d = dtt_pkg::ST_DONE;
						end
						dtt_pkg::OP_RESET: begin
							dl_we = 1'b1;
							pr_we = 1'b1;
							if (!cmd_q.rearm_now) begin
								dl_wdata = shifted;
							end
							state_d = dtt_pkg::ST_FRONT;
						end
						default: state_d = dtt_pkg::ST_DONE;
					endcase
				end
			end
			dtt_pkg::ST_FRONT: begin
				// best_q holds the target deadline; any other armed slot <= it fails
				key = best_q;
				if (scan_end) begin
					state_d = dtt_pkg::ST_DONE;
				end
			end
			dtt_pkg::ST_SCAN: begin
				key = best_q;
				if (scan_end) begin
					// park the read on the chosen slot so its period is ready to fire
					rd_addr = scan_hit ? rd_idx_q : pick_q;
					if (cmd_q.kind == dtt_pkg::OP_QUERY) begin
						state_d = dtt_pkg::ST_DONE;
					end else if (found_q || scan_hit) begin
						state_d = dtt_pkg::ST_FIRE;
					end else begin
						state_d = dtt_pkg::ST_DONE;
					end
				end
			end
			dtt_pkg::ST_FIRE: begin
				// ram holds the picked slot; rearm or retire it
				rd_addr = '0;
				wr_addr = pick_q;
				dl_we = rep_q[pick_q];
				dl_wdata = dtt_pkg::sat_add(cmd_q.now_ms, pr_rdata);
				done = 1'b1;
				result.ok = 1'b1;
				result.result_slot = pick_q;
				result.slot_present = 1'b1;
				result.last_result = (due_rest == '0);
				state_d = (due_rest == '0) ? dtt_pkg::ST_IDLE : dtt_pkg::ST_SCAN;
			end
			dtt_pkg::ST_DONE: begin
				done = 1'b1;
				result.last_result = 1'b1;
				state_d = dtt_pkg::ST_IDLE;
				case (cmd_q.kind)
					dtt_pkg::OP_ADD, dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH,
					dtt_pkg::OP_RESET: begin
						result.ok = upd_ok_q;
						result.front_notice = upd_ok_q && front_q &&
							(cmd_q.kind == dtt_pkg::OP_ADD || cmd_q.kind == dtt_pkg::OP_RESET);
					end
					dtt_pkg::OP_QUERY: begin
						result.ok = 1'b1;
						if (!found_q) begin
							result.remaining_ms = dtt_pkg::TIME_MAX;
						end else if (best_q > cmd_q.now_ms) begin
							result.remaining_ms = best_q - cmd_q.now_ms;
						end
					end
					dtt_pkg::OP_COLLECT: begin
						// only reached when nothing was due
						result.ok = 1'b1;
					end
					default: result.ok = 1'b0;
				endcase
			end
			default: state_d = dtt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtt_pkg::ST_IDLE;
			valid_q     <= '0;
			rep_q       <= '0;
			due_q       <= '0;
			notice_q    <= 1'b0;
			last_coll_q <= '0;
			window_q    <= dtt_pkg::ROLLBACK_RESET;
			idx_q       <= '0;
			rd_vld_q    <= 1'b0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			front_q     <= 1'b0;
			upd_ok_q    <= 1'b0;
			rollback_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			// scan counter: issue reads 0..NT-1, the data follows in the next cycle
			rd_vld_q <= scan_step;
			if (scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
			unique case (state_q)
				dtt_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q    <= '0;
						found_q  <= 1'b0;
						front_q  <= 1'b1;
						upd_ok_q <= 1'b0;
						if (cmd.kind == dtt_pkg::OP_COLLECT) begin
							rollback_q  <= (last_coll_q >= TB'(window_q)) &&
								(cmd.now_ms < last_coll_q - TB'(window_q));
							last_coll_q <= cmd.now_ms;
							due_q       <= valid_q;
						end
						if (cmd.kind == dtt_pkg::OP_QUERY) begin
							notice_q <= 1'b0;
						end
					end
				end
				dtt_pkg::ST_UPDATE: begin
					upd_ok_q <= !bad_slot;
					best_q   <= dl_wdata;
					if (!bad_slot) begin
						unique case (cmd_q.kind)
							dtt_pkg::OP_ADD: begin
								valid_q[cmd_q.slot] <= 1'b1;
								rep_q[cmd_q.slot]   <= cmd_q.repeat_req;
							end
							dtt_pkg::OP_CANCEL: valid_q[cmd_q.slot] <= 1'b0;
							default: ;
						endcase
					end
				end
				dtt_pkg::ST_FRONT: begin
					if (scan_end) begin
						if (front_q && !front_hit && !notice_q) begin
							notice_q <= 1'b1;
						end
						front_q <= front_q && !front_hit && !notice_q;
					end else if (front_hit) begin
						front_q <= 1'b0;
					end
				end
				dtt_pkg::ST_SCAN: begin
					if (rd_vld_q) begin
						if (cmd_q.kind == dtt_pkg::OP_QUERY) begin
							if (valid_q[rd_idx_q] && (!found_q || cmp_lt)) begin
								found_q <= 1'b1;
								best_q  <= dl_rdata;
							end
						end else if (scan_hit) begin
							found_q <= 1'b1;
							best_q  <= dl_rdata;
							pick_q  <= rd_idx_q;
						end
						if (cmd_q.kind == dtt_pkg::OP_COLLECT &&
							!(rollback_q || dl_rdata <= cmd_q.now_ms)) begin
							due_q[rd_idx_q] <= 1'b0;
						end
					end
					if (scan_end && state_d == dtt_pkg::ST_FIRE) begin
						idx_q <= '0;
					end
				end
				dtt_pkg::ST_FIRE: begin
					due_q[pick_q] <= 1'b0;
					if (!rep_q[pick_q]) begin
						valid_q[pick_q] <= 1'b0;
					end
					found_q <= 1'b0;
					idx_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q[SB-1:0];
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// assertions
	property p_busy_done;
		@(posedge clk) disable iff (!arst_n) done |-> busy;
	endproperty
	a_busy_done: assert property (p_busy_done) else $error("result outside a command");

	property p_accept_busy;
		@(posedge clk) disable iff (!arst_n) accept |=> busy;
	endproperty
	a_accept_busy: assert property (p_accept_busy) else $error("accept did not raise busy");

	property p_last_idle;
		@(posedge clk) disable iff (!arst_n) (done && result.last_result) |=> !busy;
	endproperty
	a_last_idle: assert property (p_last_idle) else $error("busy after final word");
endmodule
`default_nettype wire

>>> hw/rtl/dtt_ram.sv
// ----------------------------------------------------------------------------
// dtt_ram: generic simple dual port ram
// one write and one read address, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> dv/dtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtt_checker: predicts and checks the deadline timer table
// mirrors the timer slots, computes the result words of every taken command
// and compares each strobed result word against the oldest prediction
// ----------------------------------------------------------------------------
module dtt_checker
	import dtt_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	input  wire       busy,
	input  in_word_t  cmd,
	input  wire       done,
	input  out_word_t result,
	input  wire       cfg_valid,
	input  wire       cfg_ready,
	input  wire [31:0] cfg_data,
	output int        fails,
	output int        waiting
);
	logic                 armed    [NUM_TIMERS];
	logic                 recurring[NUM_TIMERS];
	logic [PER_BITS-1:0]  period   [NUM_TIMERS];
	logic [TIME_BITS-1:0] due_at   [NUM_TIMERS];
	logic                 notice;
	logic [TIME_BITS-1:0] collect_time;
	logic [PER_BITS-1:0]  window;
	out_word_t            words_due[$];

	function automatic logic [TIME_BITS-1:0] plus_sat(logic [TIME_BITS-1:0] a,
		logic [PER_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS+1-PER_BITS){1'b0}}, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic strictly_first(int s);
		for (int i = 0; i < NUM_TIMERS; i++)
			if (i != s && armed[i] && due_at[i] <= due_at[s]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic take_notice(int s);
		if (strictly_first(s) && !notice) begin
			notice = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_word(logic ok, logic [SLOT_BITS-1:0] sl, logic pres,
		logic [TIME_BITS-1:0] rem, logic fn, logic last);
		out_word_t w;
		w.ok = ok; w.result_slot = sl; w.slot_present = pres;
		w.remaining_ms = rem; w.front_notice = fn; w.last_result = last;
		words_due.insert(words_due.size(), w);
	endtask

	task automatic predict_words(in_word_t c);
		int s;
		logic fn;
		logic [TIME_BITS-1:0] best, d;
		logic any, roll, found;
		logic due[NUM_TIMERS];
		int pick, n;
		s = c.slot;
		fn = 1'b0;
		case (c.kind)
		OP_ADD, OP_CANCEL, OP_REFRESH, OP_RESET: begin
			if (c.kind != OP_ADD && !armed[s]) begin
				push_word(1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
				return;
			end
			case (c.kind)
			OP_ADD: begin
				armed[s] = 1'b1;
				recurring[s] = c.repeat_req;
				period[s] = c.period_ms;
				due_at[s] = plus_sat(c.now_ms, c.period_ms);
				fn = take_notice(s);
			end
			OP_CANCEL: armed[s] = 1'b0;
			OP_REFRESH: due_at[s] = plus_sat(c.now_ms, period[s]);
			default: begin
				if (c.rearm_now)
					due_at[s] = plus_sat(c.now_ms, c.period_ms);
				else if (c.period_ms >= period[s])
					due_at[s] = plus_sat(due_at[s], PER_BITS'(c.period_ms - period[s]));
				else begin
					d = TIME_BITS'(PER_BITS'(period[s] - c.period_ms));
					due_at[s] = due_at[s] > d ? due_at[s] - d : '0;
				end
				period[s] = c.period_ms;
				fn = take_notice(s);
			end
			endcase
			push_word(1'b1, '0, 1'b0, '0, fn, 1'b1);
		end
		OP_QUERY: begin
			notice = 1'b0;
			any = 1'b0;
			best = '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				if (armed[i] && (!any || due_at[i] < best)) begin
					any = 1'b1;
					best = due_at[i];
				end
			push_word(1'b1, '0, 1'b0,
				!any ? TIME_MAX : (best <= c.now_ms ? '0 : best - c.now_ms), 1'b0, 1'b1);
		end
		OP_COLLECT: begin
			// clock jumped back beyond the window: everything armed is due
			roll = collect_time >= TIME_BITS'(window) &&
				c.now_ms < collect_time - TIME_BITS'(window);
			collect_time = c.now_ms;
			for (int i = 0; i < NUM_TIMERS; i++)
				due[i] = armed[i] && (roll || due_at[i] <= c.now_ms);
			n = 0;
			do begin
				found = 1'b0;
				pick = 0;
				for (int i = 0; i < NUM_TIMERS; i++)
					if (due[i] && (!found || due_at[i] < due_at[pick])) begin
						found = 1'b1;
						pick = i;
					end
				if (found) begin
					due[pick] = 1'b0;
					if (recurring[pick]) due_at[pick] = plus_sat(c.now_ms, period[pick]);
					else armed[pick] = 1'b0;
					push_word(1'b1, SLOT_BITS'(pick), 1'b1, '0, 1'b0, 1'b0);
					n++;
				end
			end while (found);
			if (n == 0) push_word(1'b1, '0, 1'b0, '0, 1'b0, 1'b1);
			else words_due[$].last_result = 1'b1;
		end
		default: push_word(1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
		endcase
	endtask

	task automatic compare_word(out_word_t got);
		out_word_t exp;
		if (words_due.size() == 0) begin
			$error("result word with nothing expected");
			fails++;
			return;
		end
		exp = words_due.pop_front();
		if (got.ok !== exp.ok) begin
			$error("ok: expected %0d, got %0d", exp.ok, got.ok); fails++;
		end
		if (got.result_slot !== exp.result_slot) begin
			$error("result_slot: expected %0d, got %0d", exp.result_slot, got.result_slot);
			fails++;
		end
		if (got.slot_present !== exp.slot_present) begin
			$error("slot_present: expected %0d, got %0d", exp.slot_present,
				got.slot_present);
			fails++;
		end
		if (got.remaining_ms !== exp.remaining_ms) begin
			$error("remaining_ms: expected %0h, got %0h", exp.remaining_ms,
				got.remaining_ms);
			fails++;
		end
		if (got.front_notice !== exp.front_notice) begin
			$error("front_notice: expected %0d, got %0d", exp.front_notice,
				got.front_notice);
			fails++;
		end
		if (got.last_result !== exp.last_result) begin
			$error("last_result: expected %0d, got %0d", exp.last_result, got.last_result);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				armed[i] = 1'b0;
				recurring[i] = 1'b0;
				period[i] = '0;
				due_at[i] = '0;
			end
			notice = 1'b0;
			collect_time = '0;
			window = ROLLBACK_RESET;
			words_due.delete();
			fails = 0;
			waiting = 0;
		end else begin
			// results first: a new command's words always come later
			if (done) compare_word(result);
			if (start && !busy) predict_words(cmd);
			if (cfg_valid && cfg_ready) window = cfg_data;
			waiting = words_due.size();
		end
	end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the deadline timer table
// directed commands on corner cases, then random timer traffic under several
// sender gap settings and rollback windows; the checker predicts every word
// ----------------------------------------------------------------------------
module tb_top;
	import dtt_pkg::*;

	localparam int LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    cmd;
	logic        done;
	out_word_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	int          fails;
	int          waiting;
	int          cycles = 0;
	int          idle_pct;
	logic [TIME_BITS-1:0] clock_ms;

	deadline_timer_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	dtt_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.fails    (fails),
		.waiting  (waiting)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic in_word_t make_cmd(logic [2:0] op, int sl, logic [31:0] per,
		logic rep, logic fn, logic [TIME_BITS-1:0] now);
		in_word_t w;
		w.kind = op; w.slot = SLOT_BITS'(sl); w.period_ms = per;
		w.repeat_req = rep; w.rearm_now = fn; w.now_ms = now;
		return w;
	endfunction

	// drive one command word, held until the block takes it
	task automatic issue(in_word_t w);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd = w;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	// wait until every predicted word came out, then let the block settle
	task automatic drain();
		while (waiting != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_window(logic [31:0] v);
		drain();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 9) return '1;
		if (r < 15) return $urandom;
		return $urandom_range(1, 3000);
	endfunction

	function automatic logic [TIME_BITS-1:0] next_time(logic [TIME_BITS-1:0] t);
		int r;
		r = $urandom_range(99);
		if (r < 3) return TIME_BITS'({$urandom, $urandom});   // wild time
		if (r < 8) return t > 5000 ? t - $urandom_range(1, 5000) : t;   // step back
		return t + $urandom_range(0, 900);
	endfunction

	task automatic random_traffic(int n);
		int r;
		op_t op;
		in_word_t w;
		for (int k = 0; k < n; k++) begin
			clock_ms = next_time(clock_ms);
			r = $urandom_range(99);
			if (r < 30) op = OP_ADD;
			else if (r < 38) op = OP_CANCEL;
			else if (r < 46) op = OP_REFRESH;
			else if (r < 60) op = OP_RESET;
			else if (r < 80) op = OP_COLLECT;
			else op = OP_QUERY;
			w = make_cmd(op, $urandom_range(15), pick_period(), 1'($urandom_range(1)),
				1'($urandom_range(1)), clock_ms);
			// unused kinds six and seven now and then
			if ($urandom_range(99) < 4) w.kind = 3'($urandom_range(6, 7));
			issue(w);
			if (k == n / 2) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		clock_ms = 48'd1000;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corner cases
		issue(make_cmd(OP_QUERY, 0, 0, 0, 0, 48'd1000));          // empty table
		issue(make_cmd(OP_COLLECT, 0, 0, 0, 0, 48'd1000));        // nothing due
		issue(make_cmd(OP_CANCEL, 3, 0, 0, 0, 48'd1000));         // idle slot
		issue(make_cmd(OP_REFRESH, 3, 0, 0, 0, 48'd1000));
		issue(make_cmd(OP_RESET, 3, 5, 0, 1, 48'd1000));
		issue(make_cmd(OP_ADD, 0, 500, 1, 0, 48'd1000));          // front notice
		issue(make_cmd(OP_ADD, 1, 100, 0, 0, 48'd1000));          // earlier, notice pending
		issue(make_cmd(OP_QUERY, 0, 0, 0, 0, 48'd1050));
		issue(make_cmd(OP_ADD, 2, 100, 0, 0, 48'd1000));          // tie is not front
		issue(make_cmd(OP_ADD, 15, 32'hFFFF_FFFF, 1, 0, TIME_MAX)); // saturating sum
		issue(make_cmd(OP_RESET, 15, 0, 0, 0, 0));                // shift down
		issue(make_cmd(OP_RESET, 0, 0, 0, 0, 48'd1000));          // shift to below period
		issue(make_cmd(OP_RESET, 1, 32'hFFFF_FFFF, 0, 0, 48'd1000)); // shift up
		issue(make_cmd(OP_REFRESH, 2, 0, 0, 0, 48'd900));
		issue(make_cmd(OP_ADD, 4, 0, 1, 0, 48'd1000));            // recurring, due at once
		issue(make_cmd(OP_QUERY, 0, 0, 0, 0, 48'd3000));          // already due
		issue(make_cmd(OP_COLLECT, 0, 0, 0, 0, 48'd2000));
		issue(make_cmd(OP_RESET, 4, 50, 0, 1, 48'd2000));         // rearm from now
		issue(make_cmd(OP_ADD, 5, 10, 0, 0, 48'd5000000));
		issue(make_cmd(OP_COLLECT, 0, 0, 0, 0, 48'd5000000));
		issue(make_cmd(OP_COLLECT, 0, 0, 0, 0, 48'd100));         // rollback
		issue(make_cmd(OP_CANCEL, 4, 0, 0, 0, 48'd100));
		issue(make_cmd(3'd6, 0, 0, 0, 0, 48'd100));
		issue(make_cmd(3'd7, 15, '1, 1, 1, TIME_MAX));
		issue(make_cmd(OP_COLLECT, 0, 0, 0, 0, TIME_MAX));        // all due

		// random phases across gap settings and rollback windows
		clock_ms = 48'd10000;
		random_traffic(64);
		write_window(32'd0);
		idle_pct = 51;
		random_traffic(64);
		write_window(32'hFFFF_FFFF);
		idle_pct = 16;
		random_traffic(64);
		write_window(32'd700);
		idle_pct = 0;
		random_traffic(64);

		drain();
		repeat (400) @(negedge clk);
		if (fails == 0 && waiting == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> files.f
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_ram.sv
hw/rtl/deadline_timer_table.sv
dv/dtt_checker.sv
dv/tb_top.sv
